FILE: src/idra_pkg.sv
// Shared constants, codes and control types for the contiguous ID range allocator.
// No dependencies; every other file of the block imports this package.
package idra_pkg;

  // ID space and bitmap geometry
  localparam int TOTAL_IDS = 1024;
  localparam int ID_W      = $clog2(TOTAL_IDS);
  localparam int WORD_BITS = 32;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int NUM_WORDS = TOTAL_IDS / WORD_BITS;
  localparam int WADDR_W   = ID_W - OFF_W;

  // Field and register widths
  localparam int CNT_W    = 11;
  localparam int CFG_W    = 11;
  localparam int STATUS_W = 2;
  localparam int POS_W    = ID_W + 1;
  localparam int END_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [CFG_W-1:0] ID_LIMIT_RESET = CFG_W'(1024);
  localparam logic REG_ID_LIMIT = 1'b0;

  // Request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_START,
    S_SEEK_LD,
    S_SEEK,
    S_RUN_LD,
    S_RUN,
    S_MARK_LD,
    S_MARK,
    S_F_START,
    S_CHK_LD,
    S_CHK,
    S_CLR_LD,
    S_CLR,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    ld_req;
    logic    seek_set;
    logic    seek_next;
    logic    jump;
    logic    adv;
    logic    rewind;
    logic    wr_set;
    logic    wr_clr;
    logic    res_load;
    status_t res_code;
    logic    res_id;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic over_lim;
    logic hit_used;
    logic hit_free;
    logic end_in_word;
    logic zero_found;
    logic base_ge_lim;
    logic e_same_word;
  } stat_t;

endpackage

FILE: src/idra_req_if.sv
// Request channel: valid/ready handshake carrying one allocate or free transaction.
// Depends on idra_pkg for field widths.
interface idra_req_if;
  import idra_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  start_id;

  modport source (output valid, action, count, start_id, input ready);
  modport sink   (input valid, action, count, start_id, output ready);
endinterface

FILE: src/idra_rsp_if.sv
// Response channel: valid/ready handshake carrying one result transaction.
// Depends on idra_pkg for field widths.
interface idra_rsp_if;
  import idra_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     first_id;

  modport source (output valid, status, first_id, input ready);
  modport sink   (input valid, status, first_id, output ready);
endinterface

FILE: src/idra_cfg.sv
// APB-style configuration register block holding id_limit.
// Depends on idra_pkg.
module idra_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idra_pkg::PADDR_W-1:0]  paddr,
  input  logic [idra_pkg::PDATA_W-1:0]  pwdata,
  output logic [idra_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [idra_pkg::CFG_W-1:0]    id_limit
);
  import idra_pkg::*;

  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_ID_LIMIT);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit <= ID_LIMIT_RESET;
    end else if (wr_en && hit) begin
      id_limit <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = hit ? PDATA_W'(id_limit) : '0;

endmodule

FILE: src/idra_dp.sv
// Datapath: bitmap word memory, scan position registers, range masks and result registers.
// Depends on idra_pkg; driven by idra_ctrl through cmd_t and reports through stat_t.
module idra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  idra_pkg::cmd_t                cmd,
  output idra_pkg::stat_t               stat,
  input  logic                          req_action,
  input  logic [idra_pkg::CNT_W-1:0]    req_count,
  input  logic [idra_pkg::ID_W-1:0]     req_start_id,
  input  logic [idra_pkg::CFG_W-1:0]    id_limit,
  output logic [idra_pkg::STATUS_W-1:0] rsp_status,
  output logic [idra_pkg::ID_W-1:0]     rsp_first_id
);
  import idra_pkg::*;

  // Bitmap store: one bit per ID, valid bit per word stands for the cleared reset value
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvalid;
  logic [WORD_BITS-1:0] rdata;
  logic                 rvalid;

  logic [POS_W-1:0]     s;
  logic [POS_W-1:0]     i;
  logic [CNT_W-1:0]     cnt;

  logic [WADDR_W-1:0]   waddr;
  logic [OFF_W-1:0]     off;
  logic [WORD_BITS-1:0] w;
  logic [WORD_BITS-1:0] lo;
  logic [WORD_BITS-1:0] hi;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] z;
  logic [WORD_BITS-1:0] wdata;
  logic [END_W-1:0]     base;
  logic [END_W-1:0]     next_base;
  logic [END_W-1:0]     e;
  logic [END_W-1:0]     rel;
  logic [END_W-1:0]     lim;
  logic [OFF_W-1:0]     f;
  logic [POS_W-1:0]     seek_pos;
  logic                 wr_en;

  assign waddr = i[ID_W-1:OFF_W];
  assign off   = i[OFF_W-1:0];
  assign w     = rvalid ? rdata : '0;

  // Effective limit: smaller of the register and the map size
  assign lim = (END_W'(id_limit) > END_W'(TOTAL_IDS)) ? END_W'(TOTAL_IDS) : END_W'(id_limit);

  assign base      = END_W'({i[POS_W-1:OFF_W], {OFF_W{1'b0}}});
  assign next_base = base + END_W'(WORD_BITS);
  assign e         = END_W'(s) + END_W'(cnt);
  assign rel       = e - base;

  // Bits of the current word that fall inside [i, e)
  assign lo   = {WORD_BITS{1'b1}} << off;
  assign hi   = (e <= next_base) ? ~({WORD_BITS{1'b1}} << rel[OFF_W:0]) : {WORD_BITS{1'b1}};
  assign mask = lo & hi;

  // Lowest free bit at or above the current offset
  assign z = ~w & lo;
  always_comb begin
    f = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (z[k]) begin
        f = OFF_W'(k);
      end
    end
  end
  assign seek_pos = {i[POS_W-1:OFF_W], f};

  always_comb begin
    stat.cnt_zero    = (cnt == '0);
    stat.over_lim    = (e > lim);
    stat.hit_used    = |(w & mask);
    stat.hit_free    = |(~w & mask);
    stat.end_in_word = (e <= next_base);
    stat.zero_found  = |z;
    stat.base_ge_lim = (next_base >= lim);
    stat.e_same_word = (e < next_base);
  end

  assign wr_en = cmd.wr_set | cmd.wr_clr;
  assign wdata = cmd.wr_set ? (w | mask) : (w & ~mask);

  // Read every cycle at the word of i; the data is registered and lands in the next cycle
  always_ff @(posedge clk) begin
    rdata <= mem[waddr];
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= wvalid[waddr];
      if (wr_en) begin
        wvalid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      cnt <= req_count;
      if (req_action == ACT_ALLOC) begin
        s <= '0;
        i <= '0;
      end else begin
        s <= POS_W'(req_start_id);
        i <= POS_W'(req_start_id);
      end
    end else if (cmd.seek_set) begin
      s <= seek_pos;
      i <= seek_pos;
    end else if (cmd.seek_next) begin
      s <= next_base[POS_W-1:0];
      i <= next_base[POS_W-1:0];
    end else if (cmd.jump) begin
      s <= e[POS_W-1:0];
      i <= e[POS_W-1:0];
    end else if (cmd.adv) begin
      i <= next_base[POS_W-1:0];
    end else if (cmd.rewind) begin
      i <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_status   <= cmd.res_code;
      rsp_first_id <= cmd.res_id ? s[ID_W-1:0] : '0;
    end
  end

endmodule

FILE: src/idra_ctrl.sv
// Controller: request sequencing state machine and response handshake.
// Depends on idra_pkg; commands idra_dp through cmd_t.
module idra_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_action,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  idra_pkg::stat_t stat,
  output idra_pkg::cmd_t  cmd
);
  import idra_pkg::*;

  state_t  state;
  state_t  state_next;
  status_t res_code;
  status_t res_code_next;
  logic    is_free;
  logic    slot_free;

  assign slot_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_code  <= ST_OK;
      is_free   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      if (req_valid && req_ready) begin
        is_free <= (req_action == ACT_FREE);
      end
      rsp_valid <= cmd.res_load | (rsp_valid & ~rsp_ready);
    end
  end

  // Next state
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req_action == ACT_FREE) ? S_F_START : S_A_START;
        end
      end
      S_A_START: begin
        if (stat.cnt_zero) begin
          res_code_next = ST_NO_SPACE;
          state_next    = S_DONE;
        end else begin
          state_next = S_SEEK;
        end
      end
      S_SEEK_LD: state_next = S_SEEK;
      S_SEEK: begin
        if (stat.zero_found) begin
          state_next = S_RUN;
        end else if (stat.base_ge_lim) begin
          res_code_next = ST_NO_SPACE;
          state_next    = S_DONE;
        end else begin
          state_next = S_SEEK_LD;
        end
      end
      S_RUN_LD: state_next = S_RUN;
      S_RUN: begin
        if (stat.over_lim) begin
          res_code_next = ST_NO_SPACE;
          state_next    = S_DONE;
        end else if (stat.hit_used) begin
          state_next = stat.e_same_word ? S_SEEK : S_SEEK_LD;
        end else if (stat.end_in_word) begin
          state_next = S_MARK_LD;
        end else begin
          state_next = S_RUN_LD;
        end
      end
      S_MARK_LD: state_next = S_MARK;
      S_MARK: begin
        if (stat.end_in_word) begin
          res_code_next = ST_OK;
          state_next    = S_DONE;
        end else begin
          state_next = S_MARK_LD;
        end
      end
      S_F_START: begin
        if (stat.over_lim) begin
          res_code_next = ST_INVALID;
          state_next    = S_DONE;
        end else if (stat.cnt_zero) begin
          res_code_next = ST_OK;
          state_next    = S_DONE;
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK_LD: state_next = S_CHK;
      S_CHK: begin
        if (stat.hit_free) begin
          res_code_next = ST_INVALID;
          state_next    = S_DONE;
        end else if (stat.end_in_word) begin
          state_next = S_CLR_LD;
        end else begin
          state_next = S_CHK_LD;
        end
      end
      S_CLR_LD: state_next = S_CLR;
      S_CLR: begin
        if (stat.end_in_word) begin
          res_code_next = ST_OK;
          state_next    = S_DONE;
        end else begin
          state_next = S_CLR_LD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready    = 1'b0;
    cmd          = '0;
    cmd.res_code = res_code;
    cmd.res_id   = !is_free && (res_code == ST_OK);
    case (state)
      S_IDLE: begin
        req_ready  = 1'b1;
        cmd.ld_req = req_valid;
      end
      S_SEEK: begin
        cmd.seek_set  = stat.zero_found;
        cmd.seek_next = !stat.zero_found && !stat.base_ge_lim;
      end
      S_RUN: begin
        if (!stat.over_lim) begin
          cmd.jump   = stat.hit_used;
          cmd.rewind = !stat.hit_used && stat.end_in_word;
          cmd.adv    = !stat.hit_used && !stat.end_in_word;
        end
      end
      S_MARK: begin
        cmd.wr_set = 1'b1;
        cmd.adv    = !stat.end_in_word;
      end
      S_CHK: begin
        if (!stat.hit_free) begin
          cmd.rewind = stat.end_in_word;
          cmd.adv    = !stat.end_in_word;
        end
      end
      S_CLR: begin
        cmd.wr_clr = 1'b1;
        cmd.adv    = !stat.end_in_word;
      end
      S_DONE: begin
        cmd.res_load = slot_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/contiguous_id_range_allocator_core.sv
// Per request, an allocate tests its start and scans the 32-ID words for a free run, reading
//   a new word where needed, then marks each word of the run; a free checks each word of the
//   range and then clears each one. The response is registered after the last step; a stalled
//   response holds off the next request.
// Reset: all IDs free at once (per-word valid bits cleared, no clearing pass), id_limit 1024.
// Depends on idra_pkg, idra_req_if, idra_rsp_if, idra_cfg, idra_dp and idra_ctrl.
module contiguous_id_range_allocator_core (
  input  logic                         clk,
  input  logic                         rst,
  idra_req_if.sink                     req,
  idra_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [idra_pkg::PADDR_W-1:0] paddr,
  input  logic [idra_pkg::PDATA_W-1:0] pwdata,
  output logic [idra_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import idra_pkg::*;

  logic [CFG_W-1:0] id_limit;
  cmd_t             cmd;
  stat_t            stat;

  idra_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .id_limit (id_limit)
  );

  idra_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  idra_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_action   (req.action),
    .req_count    (req.count),
    .req_start_id (req.start_id),
    .id_limit     (id_limit),
    .rsp_status   (rsp.status),
    .rsp_first_id (rsp.first_id)
  );

endmodule

FILE: test/tb_top.sv
// Self-checking bench for contiguous_id_range_allocator_core: directed and random
// allocate/free traffic with id_limit changes. Uses idra_pkg, idra_req_if and idra_rsp_if.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import idra_pkg::*;

  localparam logic [PADDR_W-1:0] ID_LIMIT_ADDR = PADDR_W'(4 * int'(REG_ID_LIMIT));
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 1500;

  typedef struct {
    status_t         status;
    logic [ID_W-1:0] first_id;
  } id_result_t;

  typedef struct {
    int base;
    int len;
  } id_range_t;

  // Tracks the used-ID bitmap and the responses still owed by the block.
  class id_alloc_tracker;
    bit         used_map [TOTAL_IDS];
    int         limit_reg;
    id_result_t owed_results [$];
    int         mismatches;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      limit_reg  = int'(ID_LIMIT_RESET);
      mismatches = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] val);
      limit_reg = int'(val);
    endfunction

    function int active_limit();
      return (limit_reg > TOTAL_IDS) ? TOTAL_IDS : limit_reg;
    endfunction

    // First fit; a used bit inside a candidate run skips the start ahead by count.
    function id_result_t allocate(int cnt);
      id_result_t res;
      int lim;
      int pos;
      int k;
      res.status   = ST_NO_SPACE;
      res.first_id = '0;
      lim = active_limit();
      if (cnt == 0) return res;
      for (pos = 0; pos < lim; pos++) begin
        if (used_map[pos]) continue;
        k = pos;
        while (k < pos + cnt && k < lim) begin
          if (used_map[k]) begin
            pos += cnt - 1;
            break;
          end
          k++;
        end
        if (k == pos + cnt) begin
          for (k = pos; k < pos + cnt; k++) used_map[k] = 1'b1;
          res.status   = ST_OK;
          res.first_id = ID_W'(pos);
          return res;
        end
      end
      return res;
    endfunction

    function id_result_t release_range(int sid, int cnt);
      id_result_t res;
      int k;
      res.status   = ST_INVALID;
      res.first_id = '0;
      if (sid + cnt > active_limit()) return res;
      for (k = sid; k < sid + cnt; k++)
        if (!used_map[k]) return res;
      for (k = sid; k < sid + cnt; k++) used_map[k] = 1'b0;
      res.status = ST_OK;
      return res;
    endfunction

    function id_result_t note_request(logic act, int cnt, int sid);
      id_result_t res;
      if (act == ACT_ALLOC) res = allocate(cnt);
      else res = release_range(sid, cnt);
      owed_results.push_back(res);
      return res;
    endfunction

    task report(string msg);
      if (mismatches < 32) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [STATUS_W-1:0] got_status, logic [ID_W-1:0] got_id);
      id_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected response status=%0d first_id=%0d", got_status, got_id));
        return;
      end
      want = owed_results.pop_front();
      if (got_status !== want.status)
        report($sformatf("status got %0d want %0d", got_status, want.status));
      if (got_id !== want.first_id)
        report($sformatf("first_id got %0d want %0d", got_id, want.first_id));
    endtask

    task check_leftover();
      if (owed_results.size() != 0)
        report($sformatf("%0d responses never arrived", owed_results.size()));
    endtask
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  idra_req_if req_ch ();
  idra_rsp_if rsp_ch ();

  contiguous_id_range_allocator_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  id_alloc_tracker tracker = new();
  id_range_t       live_ranges [$];
  int              snd_idle;
  int              rcv_idle;
  bit              hold_pending;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) tracker.check_result(rsp_ch.status, rsp_ch.first_id);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic send_request(logic act, int cnt, int sid);
    id_result_t res;
    id_range_t  rng;
    while ($urandom_range(99) < snd_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.count    <= CNT_W'(cnt);
    req_ch.start_id <= ID_W'(sid);
    do @(posedge clk); while (!req_ch.ready);
    res = tracker.note_request(act, cnt, sid);
    if (act == ACT_ALLOC && res.status == ST_OK) begin
      rng.base = int'(res.first_id);
      rng.len  = cnt;
      live_ranges.push_back(rng);
    end
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_id_limit(logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ID_LIMIT_ADDR;
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_limit(val);
  endtask

  function automatic int pick_alloc_count();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 0;
    if (r < 85) return $urandom_range(1, 12);
    if (r < 96) return $urandom_range(13, 128);
    return $urandom_range(129, 1024);
  endfunction

  // Mostly allocations and whole frees of live ranges; some partial and stray frees.
  task automatic send_random_item();
    int r;
    int idx;
    int off;
    id_range_t rng;
    r = $urandom_range(99);
    if (r >= 42 && live_ranges.size() != 0 && r < 88) begin
      idx = $urandom_range(live_ranges.size() - 1);
      rng = live_ranges[idx];
      live_ranges.delete(idx);
      if (r < 80) begin
        send_request(ACT_FREE, rng.len, rng.base);
      end else begin
        off = $urandom_range(rng.len - 1);
        send_request(ACT_FREE, $urandom_range(rng.len - off), rng.base + off);
      end
    end else if (r >= 88) begin
      if ($urandom_range(9) == 0)
        send_request(ACT_FREE, $urandom_range(1024), $urandom_range(1023));
      else
        send_request(ACT_FREE, $urandom_range(16), $urandom_range(1023));
    end else begin
      send_request(ACT_ALLOC, pick_alloc_count(), $urandom_range(1023));
    end
  endtask

  task automatic run_phase(logic [CFG_W-1:0] lim, int n_items, int s_idle, int r_idle,
                           bit with_hold);
    write_id_limit(lim);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 2) hold_pending = 1'b1;
      send_random_item();
    end
    wait_idle();
  endtask

  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_ALLOC;
    req_ch.count    <= '0;
    req_ch.start_id <= '0;
    rsp_ch.ready    <= 1'b0;
    snd_idle        = 24;
    rcv_idle        = 46;
    hold_pending    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero counts, full map, range ends, the skip-ahead on a used bit.
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_FREE, 1, 0);
    send_request(ACT_ALLOC, 1, 1023);
    send_request(ACT_ALLOC, 1024, 0);
    send_request(ACT_FREE, 1, 0);
    send_request(ACT_ALLOC, 1024, 0);
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_FREE, 1, 1023);
    send_request(ACT_FREE, 2, 1023);
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_FREE, 1024, 0);
    send_request(ACT_ALLOC, 3, 0);
    send_request(ACT_ALLOC, 5, 0);
    send_request(ACT_FREE, 3, 0);
    send_request(ACT_ALLOC, 4, 0);
    send_request(ACT_ALLOC, 2, 0);
    wait_idle();
    write_id_limit(CFG_W'(2047));
    send_request(ACT_ALLOC, 1024, 0);
    send_request(ACT_FREE, 1024, 0);
    send_request(ACT_ALLOC, 1, 0);
    wait_idle();
    write_id_limit(CFG_W'(0));
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_FREE, 1, 0);
    wait_idle();
    write_id_limit(CFG_W'(1));
    send_request(ACT_FREE, 1, 0);
    send_request(ACT_ALLOC, 1, 0);
    wait_idle();
    live_ranges.delete();

    run_phase(CFG_W'(1024), 400, 24, 46, 1'b1);
    run_phase(CFG_W'($urandom_range(100, 1023)), 300, 24, 46, 1'b0);
    run_phase(CFG_W'(1), 80, 46, 24, 1'b0);
    run_phase(CFG_W'(2047), 400, 46, 24, 1'b0);
    run_phase(CFG_W'(0), 40, 0, 0, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 1024)), 300, 0, 0, 1'b0);
    run_phase(CFG_W'(1024), 180, 0, 0, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.check_leftover();
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
